[src/assert_macros.svh]
// Assertion helpers for the polygon ear block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[src/pec_pkg.sv]
//------------------------------------------------------------------------------
// pec_pkg
// Shared constants and types of the polygon ear classifier.
//------------------------------------------------------------------------------
`default_nettype none
package pec_pkg;
  localparam int MaxVertices = 32;
  localparam int CoordBits   = 16;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits;
  localparam int CrossBits   = ProdBits + 1;
  localparam int AreaBits    = 2 * CoordBits + IdxBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  // datapath operation codes
  typedef enum logic [2:0] {
    OpNone, OpLoad, OpArea, OpConvex, OpTri, OpEdge, OpEmit
  } op_e;

  // controller to datapath
  typedef struct packed {
    op_e  op;
    idx_t p;   // triangle/segment first point
    idx_t q;
    idx_t r;
    logic [1:0] slot; // sign slot to write, or sub-mode of the op
    logic clr;        // clear area accumulator / preset ear flag
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ear_ok;
    logic cvx_i;
  } stat_t;

  function automatic idx_t wrap_inc(idx_t a, cnt_t n);
    cnt_t t;
    t = {1'b0, a} + cnt_t'(1);
    return (t >= n) ? idx_t'(0) : t[IdxBits-1:0];
  endfunction

  function automatic idx_t wrap_dec(idx_t a, cnt_t n);
    cnt_t t;
    t = n - cnt_t'(1);
    return (a == idx_t'(0)) ? t[IdxBits-1:0] : a - idx_t'(1);
  endfunction
endpackage
`default_nettype wire

[src/pec_if.sv]
//------------------------------------------------------------------------------
// pec_vtx_if / pec_res_if
// Valid/ready channels for vertices and results.
//------------------------------------------------------------------------------
`default_nettype none
interface pec_vtx_if;
  import pec_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pec_res_if;
  import pec_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   is_convex;
  logic   is_ear;
  logic   is_ccw;
  logic   overflowed;
  logic   last_result;
  modport source (output valid, out_x, out_y, is_convex, is_ear, is_ccw, overflowed,
                  last_result, input ready);
  modport sink   (input valid, out_x, out_y, is_convex, is_ear, is_ccw, overflowed,
                  last_result, output ready);
endinterface
`default_nettype wire

[src/pec_datapath.sv]
//------------------------------------------------------------------------------
// pec_datapath
// Vertex memory, one cross-product unit, sign registers and ear flag.
//------------------------------------------------------------------------------
`default_nettype none
module pec_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pec_pkg::cmd_t   cmd_i,
  input  wire pec_pkg::coord_t wx_i,
  input  wire pec_pkg::coord_t wy_i,
  input  wire pec_pkg::idx_t   widx_i,
  output pec_pkg::stat_t       stat_o,
  output logic                 ccw_o,
  output pec_pkg::coord_t      ox_o,
  output pec_pkg::coord_t      oy_o,
  output logic                 ocvx_o
);
  import pec_pkg::*;

  coord_t xs_q [MaxVertices];
  coord_t ys_q [MaxVertices];
  logic [MaxVertices-1:0] cvx_q;
  logic signed [AreaBits-1:0] area_q;
  logic ccw_q;
  logic ear_q;
  logic [1:0] sg_q [4]; // edge-test signs as {neg,zero}, combined into l1..l4

  // stage 1: operand fetch (three-point read from registers)
  coord_t px, py, qx, qy, rx, ry;
  assign px = xs_q[cmd_i.p];
  assign py = ys_q[cmd_i.p];
  assign qx = xs_q[cmd_i.q];
  assign qy = ys_q[cmd_i.q];
  assign rx = xs_q[cmd_i.r];
  assign ry = ys_q[cmd_i.r];

  logic signed [DiffBits-1:0] dqx, dqy, drx, dry;
  assign dqx = DiffBits'(qx) - DiffBits'(px);
  assign dqy = DiffBits'(qy) - DiffBits'(py);
  assign drx = DiffBits'(rx) - DiffBits'(px);
  assign dry = DiffBits'(ry) - DiffBits'(py);

  // products registered, then subtracted
  logic signed [ProdBits-1:0] m1_q, m2_q;
  cmd_t c1_q;
  logic inspan_q;

  function automatic logic in_span(coord_t a, coord_t b, coord_t c);
    return (c >= a && c <= b) || (c >= b && c <= a);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
    end else begin
      c1_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpArea) begin
      // shoelace term x_p*y_q - x_q*y_p
      m1_q <= ProdBits'(px) * ProdBits'(qy);
      m2_q <= ProdBits'(qx) * ProdBits'(py);
    end else begin
      m1_q <= ProdBits'(dqx) * ProdBits'(dry);
      m2_q <= ProdBits'(drx) * ProdBits'(dqy);
    end
    inspan_q <= in_span(px, qx, rx) && in_span(py, qy, ry);
    if (cmd_i.op == OpEmit) begin
      ox_o   <= xs_q[cmd_i.p];
      oy_o   <= ys_q[cmd_i.p];
      ocvx_o <= cvx_q[cmd_i.p];
    end
    if (cmd_i.op == OpLoad) begin
      xs_q[widx_i] <= wx_i;
      ys_q[widx_i] <= wy_i;
    end
  end

  logic signed [CrossBits-1:0] cr;
  assign cr = CrossBits'(m1_q) - CrossBits'(m2_q);
  logic cneg, czero, wrong, onseg, far_cvx;
  assign cneg  = cr[CrossBits-1];
  assign czero = (cr == '0);
  assign wrong = ccw_q ? cneg : (!cneg && !czero);
  assign onseg = czero && inspan_q;
  // far check applies only when the neighbor it goes through is convex
  assign far_cvx = (c1_q.slot == 2'd1) ? cvx_q[c1_q.q] : cvx_q[c1_q.p];

  logic l1, l2, l3, l4;
  always_comb begin
    l1 = sg_q[0] != sg_q[1];
    l2 = sg_q[2] != sg_q[3];
    l3 = !sg_q[0][0] && !sg_q[1][0];
    l4 = !sg_q[2][0] && !sg_q[3][0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
      ccw_q  <= 1'b0;
      ear_q  <= 1'b0;
      cvx_q  <= '0;
      for (int k = 0; k < 4; k++) sg_q[k] <= '0;
    end else begin
      if (cmd_i.clr && cmd_i.op == OpArea) area_q <= '0;
      if (cmd_i.clr && cmd_i.op != OpArea) ear_q <= 1'b1;
      case (c1_q.op)
        OpArea: begin
          area_q <= area_q + AreaBits'(cr);
          if (c1_q.slot == 2'd1) ccw_q <= (area_q + AreaBits'(cr)) > 0;
        end
        OpConvex: cvx_q[c1_q.q] <= !wrong;
        OpTri: begin
          // slot 0: neighbor collinearity; slot 1/2: far side via next/previous
          if (c1_q.slot == 2'd0) begin
            if (czero) ear_q <= 1'b0;
          end else if (far_cvx && (onseg || wrong)) begin
            ear_q <= 1'b0;
          end
        end
        OpEdge: begin
          sg_q[c1_q.slot] <= {cneg, czero};
          if (onseg) ear_q <= 1'b0;
        end
        default: ;
      endcase
      if (cmd_i.op == OpEmit && cmd_i.slot == 2'd1 && l1 && l2 && (l3 || l4))
        ear_q <= 1'b0;
    end
  end

  assign ccw_o  = ccw_q;
  assign stat_o = '{ear_ok: ear_q, cvx_i: cvx_q[cmd_i.r]};
endmodule
`default_nettype wire

[src/pec_ctrl.sv]
//------------------------------------------------------------------------------
// pec_ctrl
// Sequencer: load, shoelace pass, convexity pass, per-vertex ear tests, emit.
//------------------------------------------------------------------------------
`default_nettype none
module pec_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_last_i,
  output logic                 in_ready_o,
  output pec_pkg::idx_t        widx_o,
  output pec_pkg::cmd_t        cmd_o,
  input  wire pec_pkg::stat_t  stat_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output logic                 res_ear_o,
  output logic                 res_last_o,
  output logic                 res_ovf_o
);
  import pec_pkg::*;

  typedef enum logic [3:0] {
    SLoad, SArea, SAreaW, SConv, SConvW, SEar, SFar1, SFar2, SEdge, SEdgeW,
    SCross, SEmit, SEmitW, SOut
  } state_e;

  state_e state_q;
  cnt_t n_q, cnt_q;
  idx_t i_q, j_q, a_q;
  logic [1:0] sub_q;
  logic ovf_q;
  cnt_t k_q;

  idx_t prv, nxt;
  assign prv = wrap_dec(i_q, n_q);
  assign nxt = wrap_inc(i_q, n_q);

  logic acc, wen;
  assign in_ready_o = (state_q == SLoad);
  assign acc   = in_valid_i && in_ready_o;
  assign wen   = acc && (cnt_q < cnt_t'(MaxVertices));
  assign widx_o = cnt_q[IdxBits-1:0];

  always_comb begin
    cmd_o = '0;
    cmd_o.op = OpNone;
    case (state_q)
      SLoad: if (wen) cmd_o.op = OpLoad;
      SArea: begin
        cmd_o.op = OpArea; cmd_o.p = i_q; cmd_o.q = wrap_inc(i_q, n_q);
        cmd_o.clr = (i_q == '0);
        cmd_o.slot = ({1'b0, i_q} + cnt_t'(1) == n_q) ? 2'd1 : 2'd0;
      end
      SConv: begin
        cmd_o.op = OpConvex; cmd_o.p = prv; cmd_o.q = i_q; cmd_o.r = nxt;
      end
      SEar: begin
        // tri(prv, nxt, i)
        cmd_o.op = OpTri; cmd_o.p = prv; cmd_o.q = nxt; cmd_o.r = i_q;
        cmd_o.slot = 2'd0; cmd_o.clr = 1'b1;
      end
      SFar1: begin
        cmd_o.op = OpTri;
        cmd_o.p = prv; cmd_o.q = nxt; cmd_o.r = wrap_inc(nxt, n_q); cmd_o.slot = 2'd1;
      end
      SFar2: begin
        cmd_o.op = OpTri;
        cmd_o.p = prv; cmd_o.q = nxt; cmd_o.r = wrap_dec(prv, n_q); cmd_o.slot = 2'd2;
      end
      SEdge: begin
        cmd_o.op = OpEdge; cmd_o.slot = sub_q;
        case (sub_q)
          2'd0: begin cmd_o.p = prv; cmd_o.q = nxt; cmd_o.r = a_q; end
          2'd1: begin cmd_o.p = prv; cmd_o.q = nxt; cmd_o.r = wrap_inc(a_q, n_q); end
          2'd2: begin cmd_o.p = a_q; cmd_o.q = wrap_inc(a_q, n_q); cmd_o.r = prv; end
          default: begin cmd_o.p = a_q; cmd_o.q = wrap_inc(a_q, n_q); cmd_o.r = nxt; end
        endcase
      end
      SCross: begin
        cmd_o.op = OpEmit; cmd_o.slot = 2'd1; cmd_o.p = i_q;
      end
      SEmit: begin
        cmd_o.op = OpEmit; cmd_o.p = i_q; cmd_o.r = i_q;
      end
      SOut: cmd_o.r = i_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad; n_q <= '0; cnt_q <= '0; i_q <= '0; j_q <= '0; a_q <= '0;
      sub_q <= '0; ovf_q <= 1'b0; k_q <= '0; res_valid_o <= 1'b0; res_ear_o <= 1'b0;
      res_last_o <= 1'b0; res_ovf_o <= 1'b0;
    end else begin
      case (state_q)
        SLoad: if (acc) begin
          cnt_q <= wen ? cnt_q + cnt_t'(1) : cnt_q;
          if (!wen) ovf_q <= 1'b1;
          if (in_last_i) begin
            n_q <= wen ? cnt_q + cnt_t'(1) : cnt_q;
            i_q <= '0;
            state_q <= SArea;
          end
        end
        SArea: if ({1'b0, i_q} + cnt_t'(1) == n_q) begin
          i_q <= '0; state_q <= SAreaW;
        end else i_q <= i_q + idx_t'(1);
        SAreaW: state_q <= SConvW;   // ccw settles after the last product
        SConvW: state_q <= SConv;
        SConv: if ({1'b0, i_q} + cnt_t'(1) == n_q) begin
          i_q <= '0; state_q <= SEmitW;
        end else i_q <= i_q + idx_t'(1);
        SEmitW: state_q <= SEar;     // last convex flag written
        SEar: state_q <= (n_q < cnt_t'(4)) ? SEmit : SFar1;
        SFar1: state_q <= SFar2;
        SFar2: begin
          a_q <= wrap_inc(nxt, n_q); k_q <= '0; sub_q <= '0;
          state_q <= (n_q > cnt_t'(4)) ? SEdge : SEmit;
        end
        SEdge: begin
          sub_q <= sub_q + 2'd1;
          if (sub_q == 2'd3) state_q <= SEdgeW;
        end
        SEdgeW: state_q <= SCross;   // fourth sign lands at the end of this cycle
        SCross: begin
          // crossing test uses the four signs of this edge
          a_q <= wrap_inc(a_q, n_q);
          k_q <= k_q + cnt_t'(1);
          state_q <= (k_q + cnt_t'(5) < n_q) ? SEdge : SEmit;
        end
        SEmit: begin
          j_q <= '0;
          state_q <= SOut;
          res_last_o <= ({1'b0, i_q} + cnt_t'(1) == n_q);
          res_ovf_o <= ovf_q;
        end
        SOut: begin
          if (!res_valid_o && j_q == '0) begin
            res_valid_o <= 1'b1;
            res_ear_o <= stat_i.ear_ok && stat_i.cvx_i && (n_q > cnt_t'(2));
            j_q <= idx_t'(1);
          end else if (res_valid_o && res_ready_i) begin
            res_valid_o <= 1'b0;
            if (res_last_o) begin
              cnt_q <= '0; ovf_q <= 1'b0; state_q <= SLoad;
            end else begin
              i_q <= i_q + idx_t'(1); state_q <= SEar;
            end
          end
        end
        default: state_q <= SLoad;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/polygon_ear_classifier_top.sv]
// After the last vertex the block runs the shoelace and convexity passes, then per vertex the
// ear tests and output handshake (far tests skipped when n < 4, edge tests when n < 5).
// Results come one at a time, the next vertex's tests waiting on the handshake and the single
// cross-product unit; input is held off from the last vertex to the final result.
// Vertices load at one per cycle. Reset is asynchronous, active low, and clears the
// controller; vertex storage holds no reset value.
//------------------------------------------------------------------------------
// polygon_ear_classifier_top
// Classifies polygon vertices as convex/reflex and ear/non-ear.
//------------------------------------------------------------------------------
`default_nettype none
module polygon_ear_classifier_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  pec_vtx_if.sink  vtx_i,
  pec_res_if.source res_o
);
  import pec_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  idx_t  widx;
  logic  ccw;

  // controller sequences every pass; datapath holds vertices and does the math
  pec_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (vtx_i.valid), .in_last_i (vtx_i.last_vertex), .in_ready_o (vtx_i.ready),
    .widx_o (widx), .cmd_o (cmd), .stat_i (stat),
    .res_valid_o (res_o.valid), .res_ready_i (res_o.ready),
    .res_ear_o (res_o.is_ear), .res_last_o (res_o.last_result),
    .res_ovf_o (res_o.overflowed)
  );

  pec_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .wx_i (vtx_i.vertex_x), .wy_i (vtx_i.vertex_y),
    .widx_i (widx), .stat_o (stat), .ccw_o (ccw),
    .ox_o (res_o.out_x), .oy_o (res_o.out_y), .ocvx_o (res_o.is_convex)
  );

  // orientation is stable for the whole emit phase
  assign res_o.is_ccw = ccw;
endmodule
`default_nettype wire

[src/pec_checker.sv]
//------------------------------------------------------------------------------
// pec_checker
// Port-level checks of the ear classifier.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pec_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic out_ear,
  input wire logic out_cvx
);
  `ASSERT_IMP(a_ear_cvx, clk_i, rst_ni, out_valid && out_ear, out_cvx)
  `ASSERT_IMP(a_no_both, clk_i, rst_ni, out_valid, !in_ready)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_reload, clk_i, rst_ni, out_valid && out_ready && out_last, !out_valid)
endmodule

bind polygon_ear_classifier_top pec_checker u_chk (
  .clk_i, .rst_ni, .in_ready (vtx_i.ready),
  .out_valid (res_o.valid), .out_ready (res_o.ready), .out_last (res_o.last_result),
  .out_ear (res_o.is_ear), .out_cvx (res_o.is_convex)
);
`default_nettype wire
